>>> rtl/core/ile_pkg.sv
// Shared types and codes for the indexed list engine.
// Depends on nothing; imported by ile_cell, indexed_list_engine and the testbench.
package ile_pkg;

   // request codes
   localparam logic [3:0] REQ_READ       = 4'd0;
   localparam logic [3:0] REQ_WRITE      = 4'd1;
   localparam logic [3:0] REQ_PUSH_BACK  = 4'd2;
   localparam logic [3:0] REQ_PUSH_FRONT = 4'd3;
   localparam logic [3:0] REQ_POP_BACK   = 4'd4;
   localparam logic [3:0] REQ_POP_FRONT  = 4'd5;
   localparam logic [3:0] REQ_INSERT     = 4'd6;
   localparam logic [3:0] REQ_ERASE      = 4'd7;
   localparam logic [3:0] REQ_CLEAR      = 4'd8;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic [3:0]         req_type;
      logic [3:0]         index;
      logic signed [31:0] value;
   } ile_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] read_value;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
      logic [4:0]         count;
      logic               is_empty;
   } ile_rsp_type;

   // operation applied to every cell at the clock edge
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctrl_type;

endpackage

>>> rtl/core/indexed_list_engine.sv
// Indexed list engine: an ordered list of DEPTH words with deque and
// indexed insert/erase requests. Depends on ile_pkg and ile_cell.
//
// Usage: drive req_data and raise start; a request transfers at a rising
// edge where start is high and busy is low. busy stays low, so a request
// may be issued in every cycle. Each request produces exactly one result:
// rsp_strobe is high for one cycle, the cycle after the request transfer,
// with rsp_data holding the status, the element read, and the front,
// back, count and empty flag of the list after the request.
// Throughput is one request per cycle. Every request, insert and erase
// included, takes effect at its transfer edge because the row of cells
// shifts all elements in parallel; front, back and the read element are
// selected from the cells in the result cycle.
// Reset (synchronous, active high) empties the list and drops any pending
// result; element contents are not cleared. The receiver cannot stall: a
// result not taken in its strobe cycle is gone.
module indexed_list_engine #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ile_pkg::ile_req_type req_data,
   output logic                 rsp_strobe,
   output ile_pkg::ile_rsp_type rsp_data
);
   import ile_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (CW > 4) ? CW : 4;
   localparam logic [CW-1:0] CntFull = CW'(DEPTH);
   localparam logic [CW-1:0] CntOne  = CW'(1);

   function automatic logic [31:0] widen(input logic [DATA_WIDTH-1:0] v);
      logic signed [63:0] ext;
      ext = 64'(signed'(v));
      return ext[31:0];
   endfunction

   logic                  accept;
   logic [CW-1:0]         count_ff, count_in;
   logic                  pend_ff;
   logic [1:0]            status_ff, status_in;
   logic                  rd_ok_ff, rd_ok_in;
   logic [PW-1:0]         rd_idx_ff;

   logic [IW-1:0]         idx_w, cnt_w;
   logic [PW-1:0]         idx_p;
   logic                  in_range, full, empty;
   logic [63:0]           val64;
   logic [DATA_WIDTH-1:0] wr_data;
   cell_ctrl_type         ctrl;
   logic [PW-1:0]         pos;

   logic [DATA_WIDTH-1:0] cell_data [DEPTH];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign idx_w    = IW'(req_data.index);
   assign cnt_w    = IW'(count_ff);
   assign idx_p    = idx_w[PW-1:0];
   assign in_range = idx_w < cnt_w;
   assign full     = count_ff == CntFull;
   assign empty    = count_ff == '0;
   // stored value is the low bits of the zero-extended input word
   assign val64    = {32'b0, req_data.value};
   assign wr_data  = val64[DATA_WIDTH-1:0];

   always_comb begin
      ctrl.op   = CELL_HOLD;
      pos       = idx_p;
      count_in  = count_ff;
      status_in = ST_OK;
      rd_ok_in  = 1'b0;
      unique case (req_data.req_type)
         REQ_READ: begin
            if (in_range) rd_ok_in = 1'b1;
            else status_in = ST_RANGE;
         end
         REQ_WRITE: begin
            if (in_range) ctrl.op = CELL_WRITE;
            else status_in = ST_RANGE;
         end
         REQ_PUSH_BACK: begin
            pos = count_ff[PW-1:0];
            if (full) begin
               status_in = ST_FULL;
            end else begin
               ctrl.op  = CELL_WRITE;
               count_in = count_ff + CntOne;
            end
         end
         REQ_PUSH_FRONT: begin
            pos = '0;
            if (full) begin
               status_in = ST_FULL;
            end else begin
               ctrl.op  = CELL_SHIFT_UP;
               count_in = count_ff + CntOne;
            end
         end
         REQ_POP_BACK: begin
            if (empty) status_in = ST_EMPTY;
            else count_in = count_ff - CntOne;
         end
         REQ_POP_FRONT: begin
            pos = '0;
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               ctrl.op  = CELL_SHIFT_DOWN;
               count_in = count_ff - CntOne;
            end
         end
         REQ_INSERT: begin
            // index check comes before the full check
            if (!in_range) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               ctrl.op  = CELL_SHIFT_UP;
               count_in = count_ff + CntOne;
            end
         end
         REQ_ERASE: begin
            if (in_range) begin
               ctrl.op  = CELL_SHIFT_DOWN;
               count_in = count_ff - CntOne;
            end else begin
               status_in = ST_RANGE;
            end
         end
         REQ_CLEAR: count_in = '0;
         default: ;
      endcase
      // no transfer: leave the cells and count alone
      if (!accept) begin
         ctrl.op  = CELL_HOLD;
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= accept;
      end
      status_ff <= status_in;
      rd_ok_ff  <= rd_ok_in;
      rd_idx_ff <= idx_p;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data, right_data;
      if (i == 0) begin : g_first
         assign left_data = wr_data;
      end else begin : g_mid
         assign left_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_inner
         assign right_data = cell_data[i+1];
      end
      ile_cell #(
         .DATA_WIDTH(DATA_WIDTH),
         .PW        (PW),
         .POS       (i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .pos       (pos),
         .wr_data   (wr_data),
         .left_data (left_data),
         .right_data(right_data),
         .data      (cell_data[i])
      );
   end

   // select read and back elements from the cells by position match
   logic [CW-1:0]         cnt_m1;
   logic [PW-1:0]         back_idx;
   logic [DATA_WIDTH-1:0] rd_sel, back_sel;

   assign cnt_m1   = count_ff - CntOne;
   assign back_idx = cnt_m1[PW-1:0];

   always_comb begin
      rd_sel   = '0;
      back_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (rd_idx_ff == PW'(i)) rd_sel = rd_sel | cell_data[i];
         if (back_idx == PW'(i)) back_sel = back_sel | cell_data[i];
      end
   end

   always_comb begin
      rsp_data.status      = status_ff;
      rsp_data.read_value  = rd_ok_ff ? widen(rd_sel) : 32'd0;
      rsp_data.front_value = (count_ff == '0) ? 32'd0 : widen(cell_data[0]);
      rsp_data.back_value  = (count_ff == '0) ? 32'd0 : widen(back_sel);
      rsp_data.count       = 5'(count_ff);
      rsp_data.is_empty    = count_ff == '0;
   end

   assign rsp_strobe = pend_ff;

endmodule

>>> rtl/core/ile_cell.sv
// One storage cell of the list chain: holds the element at position POS.
// Depends on ile_pkg for the cell control type.
module ile_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int PW         = 4,
   parameter int POS        = 0
) (
   input  logic                   clock,
   input  ile_pkg::cell_ctrl_type ctrl,
   input  logic [PW-1:0]          pos,
   input  logic [DATA_WIDTH-1:0]  wr_data,
   input  logic [DATA_WIDTH-1:0]  left_data,
   input  logic [DATA_WIDTH-1:0]  right_data,
   output logic [DATA_WIDTH-1:0]  data
);
   import ile_pkg::*;

   localparam logic [PW-1:0] MyPos = PW'(POS);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         CELL_WRITE: begin
            if (pos == MyPos) data_in = wr_data;
         end
         CELL_SHIFT_UP: begin
            // open a gap at pos: take from the lower neighbor above it
            if (MyPos > pos) data_in = left_data;
            else if (MyPos == pos) data_in = wr_data;
         end
         CELL_SHIFT_DOWN: begin
            // close pos: take from the upper neighbor
            if (MyPos >= pos) data_in = right_data;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

>>> dv/tb_indexed_list_engine.sv
// Self-checking testbench for indexed_list_engine: directed corner requests, then
// random fill/drain/mixed request phases checked against a predicted list.
// Depends on ile_pkg and the indexed_list_engine RTL.
module tb_indexed_list_engine;
   timeunit 1ns;
   timeprecision 1ps;

   import ile_pkg::*;

   localparam int LIST_DEPTH    = 16;
   localparam int RANDOM_ITEMS  = 1400;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 4;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY} request_mix_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   ile_req_type req_data = '0;
   logic        rsp_strobe;
   ile_rsp_type rsp_data;

   indexed_list_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #6 clock = ~clock;

   ile_req_type        request_backlog[$];
   ile_rsp_type        list_reply_q[$];
   logic signed [31:0] shadow_word[LIST_DEPTH];
   logic [4:0]         shadow_len = '0;
   int                 transfer_count = 0;
   int                 fail_count = 0;

   // Apply one request to the shadow list and return the reply it must produce.
   function automatic ile_rsp_type apply_list_request(ile_req_type rq);
      ile_rsp_type r;
      logic        in_range;
      logic        full;
      logic        empty;
      int          i;
      r        = '0;
      r.status = ST_OK;
      in_range = rq.index < shadow_len;
      full     = shadow_len >= LIST_DEPTH;
      empty    = shadow_len == 0;
      case (rq.req_type)
         REQ_READ: begin
            if (in_range) r.read_value = shadow_word[rq.index];
            else r.status = ST_RANGE;
         end
         REQ_WRITE: begin
            if (in_range) shadow_word[rq.index] = rq.value;
            else r.status = ST_RANGE;
         end
         REQ_PUSH_BACK: begin
            if (full) begin
               r.status = ST_FULL;
            end else begin
               shadow_word[shadow_len] = rq.value;
               shadow_len++;
            end
         end
         REQ_PUSH_FRONT: begin
            if (full) begin
               r.status = ST_FULL;
            end else begin
               for (i = shadow_len; i > 0; i--) shadow_word[i] = shadow_word[i-1];
               shadow_word[0] = rq.value;
               shadow_len++;
            end
         end
         REQ_POP_BACK: begin
            if (empty) r.status = ST_EMPTY;
            else shadow_len--;
         end
         REQ_POP_FRONT: begin
            if (empty) begin
               r.status = ST_EMPTY;
            end else begin
               for (i = 0; i + 1 < shadow_len; i++) shadow_word[i] = shadow_word[i+1];
               shadow_len--;
            end
         end
         REQ_INSERT: begin
            // index check wins over the full check
            if (!in_range) begin
               r.status = ST_RANGE;
            end else if (full) begin
               r.status = ST_FULL;
            end else begin
               for (i = shadow_len; i > rq.index; i--) shadow_word[i] = shadow_word[i-1];
               shadow_word[rq.index] = rq.value;
               shadow_len++;
            end
         end
         REQ_ERASE: begin
            if (in_range) begin
               for (i = rq.index; i + 1 < shadow_len; i++) shadow_word[i] = shadow_word[i+1];
               shadow_len--;
            end else begin
               r.status = ST_RANGE;
            end
         end
         REQ_CLEAR: shadow_len = '0;
         default: ;
      endcase
      if (shadow_len != 0) begin
         r.front_value = shadow_word[0];
         r.back_value  = shadow_word[shadow_len-1];
      end
      r.count    = shadow_len;
      r.is_empty = shadow_len == 0;
      return r;
   endfunction

   task automatic queue_request(logic [3:0] code, logic [3:0] idx, logic signed [31:0] val);
      ile_req_type rq;
      rq.req_type = code;
      rq.index    = idx;
      rq.value    = val;
      request_backlog = {request_backlog, rq};
   endtask

   function automatic logic signed [31:0] pick_value();
      logic signed [31:0] v;
      case ($urandom_range(0, 39))
         0: v = 32'sh7FFF_FFFF;
         1: v = 32'sh8000_0000;
         2: v = '0;
         3: v = -32'sd1;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   function automatic ile_req_type make_request(request_mix_type mix);
      ile_req_type rq;
      int          roll;
      roll     = $urandom_range(0, 99);
      rq.value = pick_value();
      // lean toward low indices so most indexed requests land in range
      rq.index = $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 5));
      case (mix)
         MIX_FILL: begin
            if (roll < 35)      rq.req_type = REQ_PUSH_BACK;
            else if (roll < 60) rq.req_type = REQ_PUSH_FRONT;
            else if (roll < 80) rq.req_type = REQ_INSERT;
            else if (roll < 90) rq.req_type = REQ_READ;
            else                rq.req_type = REQ_WRITE;
         end
         MIX_DRAIN: begin
            if (roll < 25)      rq.req_type = REQ_POP_BACK;
            else if (roll < 50) rq.req_type = REQ_POP_FRONT;
            else if (roll < 75) rq.req_type = REQ_ERASE;
            else if (roll < 90) rq.req_type = REQ_READ;
            else                rq.req_type = REQ_WRITE;
         end
         default: begin
            if (roll < 3)      rq.req_type = REQ_CLEAR;
            else if (roll < 5) rq.req_type = 4'($urandom_range(15, REQ_CLEAR + 1));
            else               rq.req_type = 4'($urandom_range(REQ_READ, REQ_ERASE));
         end
      endcase
      return rq;
   endfunction

   // Driver: present the next pending request, holding it until it transfers.
   always @(posedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_data <= '0;
      end else begin
         if (start && !busy) begin
            list_reply_q = {list_reply_q, apply_list_request(req_data)};
            transfer_count++;
         end
         if (!start || !busy) begin
            // no idle cycles while the transfer count is in the calm window
            if (request_backlog.size() > 0 &&
                ((transfer_count >= 500 && transfer_count < 800) ||
                 $urandom_range(0, 99) >= 14)) begin
               start    <= 1'b1;
               req_data <= request_backlog[0];
               request_backlog.delete(0);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed reply must match the oldest prediction.
   always @(posedge clock) begin
      ile_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (list_reply_q.size() == 0) begin
            $error("unexpected reply: status %0d count %0d", rsp_data.status, rsp_data.count);
            fail_count++;
         end else begin
            want = list_reply_q[0];
            list_reply_q.delete(0);
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.read_value !== want.read_value) begin
               $error("read_value: expected %0d, actual %0d",
                      want.read_value, rsp_data.read_value);
               fail_count++;
            end
            if (rsp_data.front_value !== want.front_value) begin
               $error("front_value: expected %0d, actual %0d",
                      want.front_value, rsp_data.front_value);
               fail_count++;
            end
            if (rsp_data.back_value !== want.back_value) begin
               $error("back_value: expected %0d, actual %0d",
                      want.back_value, rsp_data.back_value);
               fail_count++;
            end
            if (rsp_data.count !== want.count) begin
               $error("count: expected %0d, actual %0d", want.count, rsp_data.count);
               fail_count++;
            end
            if (rsp_data.is_empty !== want.is_empty) begin
               $error("is_empty: expected %0d, actual %0d", want.is_empty, rsp_data.is_empty);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: end the run if neither side moves for too long.
   always @(posedge clock) begin
      int still_cycles;
      if (reset || (start && !busy) || rsp_strobe) begin
         still_cycles = 0;
      end else begin
         still_cycles++;
         if (still_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      request_mix_type mix;
      int              k;

      // empty list: range and empty errors
      queue_request(REQ_READ, 4'd0, '0);
      queue_request(REQ_ERASE, 4'd0, '0);
      queue_request(REQ_POP_BACK, 4'd0, '0);
      queue_request(REQ_POP_FRONT, 4'd0, '0);
      queue_request(REQ_WRITE, 4'd0, 32'sd5);
      queue_request(REQ_INSERT, 4'd0, 32'sd6);
      // extremes at both ends, indexed access
      queue_request(REQ_PUSH_BACK, 4'd0, 32'sh7FFF_FFFF);
      queue_request(REQ_PUSH_FRONT, 4'd0, 32'sh8000_0000);
      queue_request(REQ_INSERT, 4'd1, '0);
      queue_request(REQ_WRITE, 4'd2, -32'sd1);
      queue_request(REQ_READ, 4'd2, '0);
      queue_request(REQ_READ, 4'd15, '0);
      queue_request(REQ_ERASE, 4'd1, '0);
      // fill to capacity
      for (k = 0; k < LIST_DEPTH - 2; k++)
         queue_request(k[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK, 4'd0, $urandom);
      queue_request(REQ_PUSH_BACK, 4'd0, 32'sd1);
      queue_request(REQ_PUSH_FRONT, 4'd0, 32'sd2);
      queue_request(REQ_INSERT, 4'd15, 32'sd3);
      queue_request(REQ_READ, 4'd15, '0);
      queue_request(REQ_ERASE, 4'd15, '0);
      queue_request(REQ_INSERT, 4'd15, 32'sd4);
      queue_request(REQ_INSERT, 4'd0, 32'sd7);
      queue_request(REQ_CLEAR + 4'd1, 4'd15, -32'sd1);
      queue_request(4'hF, 4'd15, -32'sd1);
      queue_request(REQ_POP_BACK, 4'd0, '0);
      queue_request(REQ_POP_FRONT, 4'd0, '0);
      queue_request(REQ_CLEAR, 4'd0, '0);
      queue_request(REQ_READ, 4'd0, '0);

      // random phases that swing the list between empty and full
      mix = MIX_ANY;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 40 == 0) mix = request_mix_type'($urandom_range(MIX_FILL, MIX_ANY));
         request_backlog = {request_backlog, make_request(mix)};
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (request_backlog.size() > 0 || start) @(posedge clock);
      while (list_reply_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && list_reply_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/ile_pkg.sv
rtl/core/ile_cell.sv
rtl/core/indexed_list_engine.sv
dv/tb_indexed_list_engine.sv
